// ===== src/energy_beat_detector_top_defines.svh =====
// assertion macros shared by the energy beat detector modules
`ifndef ENERGY_BEAT_DETECTOR_TOP_DEFINES_SVH
`define ENERGY_BEAT_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EBD_ASSERT_IMP(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define EBD_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/ebd_pkg.sv =====
package ebd_pkg;

  localparam int STRIDE_W    = 7;
  localparam int LWIN_W      = 16;
  localparam int AWIN_W      = 11;
  localparam int THR_W       = 16;
  localparam int SENS_W      = 16;
  localparam int MUL_B_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int LEVEL_CNT_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int LEVEL_SHIFT = 7;
  localparam int THR_FRAC    = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEREO_ENABLE       = 3'd0,
    REG_SAMPLE_STRIDE       = 3'd1,
    REG_LEVEL_WINDOW        = 3'd2,
    REG_AVERAGE_WINDOW      = 3'd3,
    REG_THRESHOLD_FACTOR    = 3'd4,
    REG_SENSITIVITY         = 3'd5,
    REG_BEAT_REPORT_ENABLE  = 3'd6,
    REG_LEVEL_REPORT_ENABLE = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                stereo_enable;
    logic [STRIDE_W-1:0] sample_stride;
    logic [LWIN_W-1:0]   level_window;
    logic [AWIN_W-1:0]   average_window;
    logic [THR_W-1:0]    threshold_factor;
    logic [SENS_W-1:0]   sensitivity;
    logic                beat_report_enable;
    logic                level_report_enable;
  } cfg_t;

endpackage

// ===== src/energy_beat_detector_top.sv =====
// channel  | handshake              | payload
// in       | in_valid / in_stall    | left_sample, right_sample, block_end
// out      | out_valid / out_stall  | beat_detected, level_valid, signal_level,
//          |                        | instant_energy, average_energy
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready is always high)
//
// a frame without block end is only accumulated in the front and gives no item
// a block-end frame is worked through in the back by the one-bit-a-cycle divider, which
//   runs twice per block; up to four block ends wait in the queue, and the front stalls
//   when it is full as well as while the stride phase is being recomputed
// a change of sample_stride stalls the input while the stride phase of the current
//   block is recomputed
// rst is synchronous, active high; it clears all control and energy state

module energy_beat_detector_top import ebd_pkg::*; #(
  parameter int SAMPLE_BITS      = 24,
  parameter int SUM_BITS         = 48,
  parameter int BLOCK_COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          block_end,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          beat_detected,
  output logic                          level_valid,
  output logic [SAMPLE_BITS-1:0]        signal_level,
  output logic [SAMPLE_BITS-2:0]        instant_energy,
  output logic [SAMPLE_BITS-2:0]        average_energy,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cfg_t              cfg;
  logic              q_full;
  logic              push;
  logic [SUM_BITS:0] push_data;
  logic              q_valid;
  logic              q_pop;
  logic [SUM_BITS:0] q_head;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file, each field keeps its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stereo_enable       <= 1'b0;
      cfg.sample_stride       <= STRIDE_W'(1);
      cfg.level_window        <= LWIN_W'(1024);
      cfg.average_window      <= AWIN_W'(64);
      cfg.threshold_factor    <= THR_W'(5325);
      cfg.sensitivity         <= SENS_W'(256);
      cfg.beat_report_enable  <= 1'b0;
      cfg.level_report_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEREO_ENABLE:       cfg.stereo_enable       <= cfg_data[0];
        REG_SAMPLE_STRIDE:       cfg.sample_stride       <= cfg_data[STRIDE_W-1:0];
        REG_LEVEL_WINDOW:        cfg.level_window        <= cfg_data[LWIN_W-1:0];
        REG_AVERAGE_WINDOW:      cfg.average_window      <= cfg_data[AWIN_W-1:0];
        REG_THRESHOLD_FACTOR:    cfg.threshold_factor    <= cfg_data[THR_W-1:0];
        REG_SENSITIVITY:         cfg.sensitivity         <= cfg_data[SENS_W-1:0];
        REG_BEAT_REPORT_ENABLE:  cfg.beat_report_enable  <= cfg_data[0];
        REG_LEVEL_REPORT_ENABLE: cfg.level_report_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: magnitude sum, stride phase, level period count
  ebd_front #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SUM_BITS         (SUM_BITS),
    .BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .block_end    (block_end),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  // block-end jobs: block sum plus level-period flag
  ebd_queue #(
    .WIDTH (SUM_BITS + 1)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back: average update, instant energy, beat test, level, output register
  ebd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .beat_detected  (beat_detected),
    .level_valid    (level_valid),
    .signal_level   (signal_level),
    .instant_energy (instant_energy),
    .average_energy (average_energy)
  );

endmodule

// ===== src/ebd_front.sv =====
`include "energy_beat_detector_top_defines.svh"

module ebd_front import ebd_pkg::*; #(
  parameter int SAMPLE_BITS      = 24,
  parameter int SUM_BITS         = 48,
  parameter int BLOCK_COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          block_end,
  input  logic                          q_full,
  output logic                          push,
  output logic [SUM_BITS:0]             push_data
);

  localparam int RCNT_W = $clog2(BLOCK_COUNT_BITS + 1);

  logic [BLOCK_COUNT_BITS-1:0] frame;
  logic [BLOCK_COUNT_BITS-1:0] frame_sh;
  logic [STRIDE_W-1:0]         phase;
  logic [STRIDE_W-1:0]         phase_stride;
  logic [STRIDE_W-1:0]         rem;
  logic [RCNT_W-1:0]           rcnt;
  logic                        busy;
  logic [SUM_BITS-1:0]         sum;
  logic [LEVEL_CNT_W-1:0]      cnt;

  logic [STRIDE_W-1:0]    stride_eff;
  logic [LWIN_W-1:0]      lw_eff;
  logic                   mismatch;
  logic                   accept;
  logic [STRIDE_W:0]      rem_shift;
  logic [STRIDE_W-1:0]    rem_next;
  logic [SAMPLE_BITS-1:0] left_u, right_u, mag_l, mag_r;
  logic [SAMPLE_BITS:0]   add;
  logic [SUM_BITS+1:0]    sum_wide;
  logic [SUM_BITS-1:0]    sum_sat;
  logic [LEVEL_CNT_W-1:0] cnt_inc;
  logic                   level_hit;
  logic [STRIDE_W:0]      phase_inc;

  assign stride_eff = (cfg.sample_stride == '0) ? STRIDE_W'(1) : cfg.sample_stride;
  assign lw_eff     = (cfg.level_window == '0) ? LWIN_W'(1) : cfg.level_window;
  assign mismatch   = stride_eff != phase_stride;
  assign in_stall   = busy | mismatch | q_full;
  assign accept     = in_valid & ~in_stall;

  // restoring remainder of the frame position by a new stride, one bit a cycle
  assign rem_shift = {rem, frame_sh[BLOCK_COUNT_BITS-1]};
  assign rem_next  = (rem_shift >= {1'b0, phase_stride}) ?
                     STRIDE_W'(rem_shift - {1'b0, phase_stride}) : rem_shift[STRIDE_W-1:0];

  assign left_u  = left_sample;
  assign right_u = right_sample;
  assign mag_l   = left_u[SAMPLE_BITS-1] ? (~left_u + SAMPLE_BITS'(1)) : left_u;
  assign mag_r   = right_u[SAMPLE_BITS-1] ? (~right_u + SAMPLE_BITS'(1)) : right_u;

  assign add      = (phase == '0) ?
                    ({1'b0, mag_l} + (cfg.stereo_enable ? {1'b0, mag_r} : '0)) : '0;
  assign sum_wide = {2'b00, sum} + (SUM_BITS+2)'(add);
  assign sum_sat  = (|sum_wide[SUM_BITS+1:SUM_BITS]) ? '1 : sum_wide[SUM_BITS-1:0];

  assign cnt_inc   = (&cnt) ? cnt : cnt + LEVEL_CNT_W'(1);
  assign level_hit = cnt_inc >= LEVEL_CNT_W'(lw_eff);
  assign phase_inc = {1'b0, phase} + (STRIDE_W+1)'(1);

  assign push      = accept & block_end;
  assign push_data = {level_hit, sum_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame        <= '0;
      phase        <= '0;
      phase_stride <= STRIDE_W'(1);
      busy         <= 1'b0;
      rcnt         <= '0;
      sum          <= '0;
      cnt          <= '0;
    end else if (busy) begin
      frame_sh <= frame_sh << 1;
      rem      <= rem_next;
      rcnt     <= rcnt - RCNT_W'(1);
      if (rcnt == RCNT_W'(1)) begin
        busy  <= 1'b0;
        phase <= rem_next;
      end
    end else if (mismatch) begin
      busy         <= 1'b1;
      phase_stride <= stride_eff;
      frame_sh     <= frame;
      rem          <= '0;
      rcnt         <= RCNT_W'(BLOCK_COUNT_BITS);
    end else if (accept) begin
      if (block_end) begin
        frame <= '0;
        phase <= '0;
        if (level_hit) begin
          sum <= '0;
          cnt <= '0;
        end else begin
          sum <= sum_sat;
          cnt <= cnt_inc;
        end
      end else begin
        frame <= frame + BLOCK_COUNT_BITS'(1);
        sum   <= sum_sat;
        cnt   <= cnt_inc;
        if ((&frame) || (phase_inc == {1'b0, phase_stride})) begin
          phase <= '0;
        end else begin
          phase <= phase_inc[STRIDE_W-1:0];
        end
      end
    end
  end

  `EBD_ASSERT_IMP(a_phase_in_range, clk, rst, accept, phase < phase_stride)
  `EBD_ASSERT_IMP(a_no_push_when_full, clk, rst, push, !q_full)

endmodule

// ===== src/ebd_queue.sv =====
`include "energy_beat_detector_top_defines.svh"

module ebd_queue import ebd_pkg::*; #(
  parameter int WIDTH = 49
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  `EBD_ASSERT_IMP(a_pop_only_nonempty, clk, rst, pop, head_valid)

endmodule

// ===== src/ebd_div.sv =====
module ebd_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DEN_W:0]   r_shift;
  logic             ge;
  logic [DEN_W-1:0] rem_n;

  // one quotient bit a cycle
  assign r_shift = {rem, q[NUM_W-1]};
  assign ge      = r_shift >= {1'b0, d};
  assign rem_n   = ge ? DEN_W'(r_shift - {1'b0, d}) : r_shift[DEN_W-1:0];
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        q    <= num;
        rem  <= '0;
        d    <= den;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        q   <= {q[NUM_W-2:0], ge};
        rem <= rem_n;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/ebd_back.sv =====
`include "energy_beat_detector_top_defines.svh"

module ebd_back import ebd_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int SUM_BITS    = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  input  logic [SUM_BITS:0]        q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     beat_detected,
  output logic                     level_valid,
  output logic [SAMPLE_BITS-1:0]   signal_level,
  output logic [SAMPLE_BITS-2:0]   instant_energy,
  output logic [SAMPLE_BITS-2:0]   average_energy
);

  localparam int EW     = SAMPLE_BITS - 1;
  localparam int PROD_W = EW + MUL_B_W;
  localparam int DEN_W  = LWIN_W + 1;
  localparam int NUM_W  = (SUM_BITS > PROD_W + 1) ? SUM_BITS : PROD_W + 1;
  localparam int LV_TOP = LEVEL_SHIFT + SAMPLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_MUL,
    S_AVG_DIV,
    S_INST_DIV,
    S_BEAT_MUL,
    S_LEVEL_MUL,
    S_OUT
  } state_t;

  state_t              state;
  logic [SUM_BITS-1:0] job_sum;
  logic                job_lvl;
  logic [EW-1:0]       inst_reg;
  logic [EW-1:0]       avg_reg;
  logic [EW-1:0]       inst_new;
  logic [EW-1:0]       avg_q;
  logic [PROD_W-1:0]   prod;
  logic                beat;
  logic                div_go;

  logic [AWIN_W-1:0]  aw_eff;
  logic [LWIN_W-1:0]  lw_eff;
  logic [EW-1:0]      mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [PROD_W:0]    avg_num;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic [EW-1:0]      quot_sat;
  logic               beat_cmp;
  logic [SAMPLE_BITS-1:0] level_sat;
  logic               out_free;

  assign aw_eff = (cfg.average_window == '0) ? AWIN_W'(1) : cfg.average_window;
  assign lw_eff = (cfg.level_window == '0) ? LWIN_W'(1) : cfg.level_window;

  // one shared multiplier, operands picked by step
  always_comb begin
    case (state)
      S_BEAT_MUL: begin
        mul_a = avg_q;
        mul_b = cfg.threshold_factor;
      end
      S_LEVEL_MUL: begin
        mul_a = inst_new;
        mul_b = cfg.sensitivity;
      end
      default: begin
        mul_a = avg_reg;
        mul_b = MUL_B_W'(aw_eff - AWIN_W'(1));
      end
    endcase
  end
  assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{EW{1'b0}}, mul_b};

  assign avg_num = {1'b0, prod} + {{(PROD_W+1-EW){1'b0}}, inst_reg};
  assign div_num = (state == S_INST_DIV) ? NUM_W'(job_sum) : NUM_W'(avg_num);
  assign div_den = (state == S_INST_DIV) ?
                   (cfg.stereo_enable ? {lw_eff, 1'b0} : {1'b0, lw_eff}) :
                   DEN_W'(aw_eff);

  ebd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign quot_sat  = (|div_quot[NUM_W-1:EW]) ? '1 : div_quot[EW-1:0];
  assign beat_cmp  = PROD_W'({inst_new, {THR_FRAC{1'b0}}}) > prod;
  assign level_sat = (|prod[PROD_W-1:LV_TOP]) ? '1 : prod[LV_TOP-1:LEVEL_SHIFT];
  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_go    <= 1'b0;
      inst_reg  <= '0;
      avg_reg   <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job_sum <= q_head[SUM_BITS-1:0];
            job_lvl <= q_head[SUM_BITS];
            state   <= S_AVG_MUL;
          end
        end
        S_AVG_MUL: begin
          prod   <= mul_p;
          div_go <= 1'b1;
          state  <= S_AVG_DIV;
        end
        S_AVG_DIV: begin
          if (div_done) begin
            avg_q  <= quot_sat;
            div_go <= 1'b1;
            state  <= S_INST_DIV;
          end else begin
            div_go <= 1'b0;
          end
        end
        S_INST_DIV: begin
          div_go <= 1'b0;
          if (div_done) begin
            inst_new <= quot_sat;
            state    <= S_BEAT_MUL;
          end
        end
        S_BEAT_MUL: begin
          prod  <= mul_p;
          state <= S_LEVEL_MUL;
        end
        S_LEVEL_MUL: begin
          beat <= beat_cmp;
          if (beat_cmp) begin
            avg_q <= inst_new;
          end
          prod  <= mul_p;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            beat_detected  <= beat & cfg.beat_report_enable;
            level_valid    <= job_lvl & cfg.level_report_enable;
            signal_level   <= (job_lvl & cfg.level_report_enable) ? level_sat : '0;
            instant_energy <= inst_new;
            average_energy <= avg_q;
            inst_reg       <= inst_new;
            avg_reg        <= avg_q;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `EBD_ASSERT_IMP(a_done_in_div, clk, rst, div_done, (state == S_AVG_DIV) || (state == S_INST_DIV))
  `EBD_ASSERT_NEXT(a_out_loaded, clk, rst, (state == S_OUT) && out_free, out_valid)

endmodule
